/* rtl/core/coulomb_pair_force_top_macros.svh */
// Assertion macros shared by the checker of the Coulomb pair force block
`ifndef COULOMB_PAIR_FORCE_TOP_MACROS_SVH
`define COULOMB_PAIR_FORCE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define CPF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define CPF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/cpf_pkg.sv */
// Package: widths, reset values and the result word of the Coulomb pair force block
package cpf_pkg;

   // coordinate width default and fixed field widths
   localparam int COORD_WIDTH_DEF = 32;
   localparam int CHARGE_W        = 16;
   localparam int FORCE_W         = 32;
   localparam int SCALE_W         = 16;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd6554;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   // datapath widths
   localparam int E_W        = 31;            // scaled difference magnitude
   localparam int SQ_W       = 2 * E_W;       // one square
   localparam int SUM_W      = 64;            // sum of squares
   localparam int SQRT_STEPS = SUM_W / 2;     // one root bit per stage
   localparam int ROOT_W     = SUM_W / 2;
   localparam int QMAG_W     = 31;            // |charge_a * charge_b|
   localparam int CONST_W    = SCALE_W + QMAG_W;
   localparam int LIMB_W     = 32;
   localparam int PLO_W      = LIMB_W + E_W;
   localparam int PHI_W      = CONST_W - LIMB_W + E_W;
   localparam int PROD_W     = CONST_W + E_W;
   localparam int FRAC_W     = 16;
   localparam int NUM_W      = PROD_W + FRAC_W;
   localparam int DEN_W      = 3 * ROOT_W;

   // one result word
   typedef struct packed {
      logic signed [FORCE_W-1:0] force_x;
      logic signed [FORCE_W-1:0] force_y;
      logic signed [FORCE_W-1:0] force_z;
      logic                      coincident;
      logic                      saturated;
   } rsp_word_type;

endpackage

/* rtl/core/cpf_if.sv */
// Channel interfaces: particle pair request and force response
interface cpf_req_if #(parameter int POS_W = cpf_pkg::COORD_WIDTH_DEF);
   import cpf_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [POS_W-1:0]    a_x;
   logic signed [POS_W-1:0]    a_y;
   logic signed [POS_W-1:0]    a_z;
   logic signed [POS_W-1:0]    b_x;
   logic signed [POS_W-1:0]    b_y;
   logic signed [POS_W-1:0]    b_z;
   logic signed [CHARGE_W-1:0] charge_a;
   logic signed [CHARGE_W-1:0] charge_b;
   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, charge_a, charge_b,
                   input ready);
   modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, charge_a, charge_b,
                   output ready);
endinterface

interface cpf_rsp_if;
   import cpf_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [FORCE_W-1:0] force_x;
   logic signed [FORCE_W-1:0] force_y;
   logic signed [FORCE_W-1:0] force_z;
   logic                      coincident;
   logic                      saturated;
   modport source (output valid, force_x, force_y, force_z, coincident, saturated,
                   input ready);
   modport sink   (input valid, force_x, force_y, force_z, coincident, saturated,
                   output ready);
endinterface

/* rtl/core/cpf_pipe.sv */
// Force datapath: difference, root, cube and long division, one pair per cycle while en is high
module cpf_pipe #(
   parameter int COORD_WIDTH = cpf_pkg::COORD_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [COORD_WIDTH-1:0]       a_pos [3],
   input  logic signed [COORD_WIDTH-1:0]       b_pos [3],
   input  logic signed [cpf_pkg::CHARGE_W-1:0] charge_a,
   input  logic signed [cpf_pkg::CHARGE_W-1:0] charge_b,
   input  logic [cpf_pkg::SCALE_W-1:0]         scale,
   output logic                                out_valid,
   output cpf_pkg::rsp_word_type               out_word
);
   import cpf_pkg::*;

   localparam int DW  = COORD_WIDTH + 1;
   localparam int MW  = (DW > LIMB_W) ? DW : LIMB_W;
   localparam int KW  = $clog2(MW - 29);
   localparam int SW  = KW + 1;
   localparam int NST = 6 + SQRT_STEPS + 3 + NUM_W + 2;

   typedef struct packed {
      logic [2:0]    neg;
      logic          coin;
      logic [KW-1:0] k;
   } side_type;

   typedef logic [2:0][PROD_W-1:0] prod_type;

   // valid bits travel alongside the data
   logic [NST-1:0] valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NST-2:0], in_valid};
      end
   end
   assign out_valid = valid_ff[NST-1];

   // stage 1: differences and charge product
   logic [DW-1:0]    d1_in [3];
   logic [DW-1:0]    d1_ff [3];
   logic signed [31:0] qab1_in, qab1_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d1_in[i] = {a_pos[i][COORD_WIDTH-1], a_pos[i]} - {b_pos[i][COORD_WIDTH-1], b_pos[i]};
      end
      qab1_in = charge_a * charge_b;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff   <= d1_in;
         qab1_ff <= qab1_in;
      end
   end

   // stage 2: magnitudes and signs
   logic [DW-1:0]     mag2_in [3];
   logic [DW-1:0]     mag2_ff [3];
   logic [2:0]        dneg2_in, dneg2_ff;
   logic              qneg2_ff, coin2_in, coin2_ff;
   logic [QMAG_W-1:0] qmag2_in, qmag2_ff;
   logic [31:0]       qabs2;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dneg2_in[i] = d1_ff[i][DW-1];
         mag2_in[i]  = dneg2_in[i] ? (~d1_ff[i] + 1'b1) : d1_ff[i];
      end
      coin2_in = (d1_ff[0] == '0) && (d1_ff[1] == '0) && (d1_ff[2] == '0);
      qabs2    = qab1_ff[31] ? (~qab1_ff + 1'b1) : qab1_ff;
      qmag2_in = qabs2[QMAG_W-1:0];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         mag2_ff  <= mag2_in;
         dneg2_ff <= dneg2_in;
         qneg2_ff <= qab1_ff[31];
         coin2_ff <= coin2_in;
         qmag2_ff <= qmag2_in;
      end
   end

   // stage 3: force constant and normalising shift
   logic [CONST_W-1:0] c3_in, c3_ff;
   logic [MW-1:0]      orv3;
   side_type           side3_in, side3_ff;
   logic [DW-1:0]      mag3_ff [3];
   always_comb begin
      c3_in         = CONST_W'(scale) * CONST_W'(qmag2_ff);
      orv3          = MW'(mag2_ff[0] | mag2_ff[1] | mag2_ff[2]);
      side3_in.k    = '0;
      for (int j = LIMB_W - 1; j < MW; j++) begin
         if (orv3[j]) side3_in.k = KW'(j - 30);
      end
      side3_in.neg  = dneg2_ff ^ {3{qneg2_ff}};
      side3_in.coin = coin2_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         c3_ff    <= c3_in;
         side3_ff <= side3_in;
         mag3_ff  <= mag2_ff;
      end
   end

   // stage 4: shift magnitudes into 31 bits
   logic [E_W-1:0]     e4_in [3];
   logic [E_W-1:0]     e4_ff [3];
   logic [MW-1:0]      sh4 [3];
   logic [CONST_W-1:0] c4_ff;
   side_type           side4_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sh4[i]   = MW'(mag3_ff[i]) >> side3_ff.k;
         e4_in[i] = sh4[i][E_W-1:0];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         e4_ff    <= e4_in;
         c4_ff    <= c3_ff;
         side4_ff <= side3_ff;
      end
   end

   // stage 5: squares and partial products of the numerator
   logic [SQ_W-1:0]  sq5_in [3];
   logic [SQ_W-1:0]  sq5_ff [3];
   logic [PLO_W-1:0] plo5_in [3];
   logic [PLO_W-1:0] plo5_ff [3];
   logic [PHI_W-1:0] phi5_in [3];
   logic [PHI_W-1:0] phi5_ff [3];
   side_type         side5_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq5_in[i]  = SQ_W'(e4_ff[i]) * SQ_W'(e4_ff[i]);
         plo5_in[i] = PLO_W'(c4_ff[LIMB_W-1:0]) * PLO_W'(e4_ff[i]);
         phi5_in[i] = PHI_W'(c4_ff[CONST_W-1:LIMB_W]) * PHI_W'(e4_ff[i]);
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         sq5_ff   <= sq5_in;
         plo5_ff  <= plo5_in;
         phi5_ff  <= phi5_in;
         side5_ff <= side4_ff;
      end
   end

   // stage 6: sum of squares and full numerator products
   logic [SUM_W-1:0] sum6_in, sum6_ff;
   prod_type         p6_in, p6_ff;
   side_type         side6_ff;
   always_comb begin
      sum6_in = SUM_W'(sq5_ff[0]) + SUM_W'(sq5_ff[1]) + SUM_W'(sq5_ff[2]);
      for (int i = 0; i < 3; i++) begin
         p6_in[i] = PROD_W'(plo5_ff[i]) + (PROD_W'(phi5_ff[i]) << LIMB_W);
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         sum6_ff  <= sum6_in;
         p6_ff    <= p6_in;
         side6_ff <= side5_ff;
      end
   end

   // root stages: one result bit per stage
   logic [SUM_W-1:0] rem_ff  [SQRT_STEPS];
   logic [SUM_W-1:0] res_ff  [SQRT_STEPS];
   prod_type         sp_ff   [SQRT_STEPS];
   side_type         sside_ff [SQRT_STEPS];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * j);
      logic [SUM_W-1:0] rem_src, res_src, trial, rem_in, res_in;
      prod_type         p_src;
      side_type         side_src;
      if (j == 0) begin : g_first
         assign rem_src  = sum6_ff;
         assign res_src  = '0;
         assign p_src    = p6_ff;
         assign side_src = side6_ff;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign res_src  = res_ff[j-1];
         assign p_src    = sp_ff[j-1];
         assign side_src = sside_ff[j-1];
      end
      always_comb begin
         trial = res_src + BIT;
         if (rem_src >= trial) begin
            rem_in = rem_src - trial;
            res_in = (res_src >> 1) + BIT;
         end else begin
            rem_in = rem_src;
            res_in = res_src >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]   <= rem_in;
            res_ff[j]   <= res_in;
            sp_ff[j]    <= p_src;
            sside_ff[j] <= side_src;
         end
      end
   end

   // stage 7: square of the root
   logic [ROOT_W-1:0]   rk7_ff;
   logic [2*ROOT_W-1:0] rk2_7_in, rk2_7_ff;
   prod_type            p7_ff;
   side_type            side7_ff;
   assign rk2_7_in = (2*ROOT_W)'(res_ff[SQRT_STEPS-1][ROOT_W-1:0]) *
                     (2*ROOT_W)'(res_ff[SQRT_STEPS-1][ROOT_W-1:0]);
   always_ff @(posedge clock) begin
      if (en) begin
         rk7_ff   <= res_ff[SQRT_STEPS-1][ROOT_W-1:0];
         rk2_7_ff <= rk2_7_in;
         p7_ff    <= sp_ff[SQRT_STEPS-1];
         side7_ff <= sside_ff[SQRT_STEPS-1];
      end
   end

   // stage 8: cube as two partial products
   logic [2*ROOT_W-1:0] pplo8_in, pplo8_ff, pphi8_in, pphi8_ff;
   prod_type            p8_ff;
   side_type            side8_ff;
   assign pplo8_in = (2*ROOT_W)'(rk2_7_ff[ROOT_W-1:0]) * (2*ROOT_W)'(rk7_ff);
   assign pphi8_in = (2*ROOT_W)'(rk2_7_ff[2*ROOT_W-1:ROOT_W]) * (2*ROOT_W)'(rk7_ff);
   always_ff @(posedge clock) begin
      if (en) begin
         pplo8_ff <= pplo8_in;
         pphi8_ff <= pphi8_in;
         p8_ff    <= p7_ff;
         side8_ff <= side7_ff;
      end
   end

   // stage 9: full divisor and numerators
   logic [DEN_W-1:0]           den9_in, den9_ff;
   logic [2:0][NUM_W-1:0]      num9_in, num9_ff;
   side_type                   side9_ff;
   always_comb begin
      den9_in = DEN_W'(pplo8_ff) + (DEN_W'(pphi8_ff) << ROOT_W);
      for (int i = 0; i < 3; i++) begin
         num9_in[i] = NUM_W'(p8_ff[i]) << FRAC_W;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         den9_ff  <= den9_in;
         num9_ff  <= num9_in;
         side9_ff <= side8_ff;
      end
   end

   // division stages: one quotient bit per lane per stage
   logic [2:0][DEN_W-1:0] drem_ff  [NUM_W];
   logic [2:0][NUM_W-1:0] nq_ff    [NUM_W];
   logic [DEN_W-1:0]      dden_ff  [NUM_W];
   side_type              dside_ff [NUM_W];

   for (genvar j = 0; j < NUM_W; j++) begin : g_div
      logic [2:0][DEN_W-1:0] rem_src, rem_in;
      logic [2:0][NUM_W-1:0] nq_src, nq_in;
      logic [DEN_W-1:0]      den_src;
      side_type              side_src;
      logic [DEN_W:0]        t [3];
      if (j == 0) begin : g_first
         assign rem_src  = '0;
         assign nq_src   = num9_ff;
         assign den_src  = den9_ff;
         assign side_src = side9_ff;
      end else begin : g_next
         assign rem_src  = drem_ff[j-1];
         assign nq_src   = nq_ff[j-1];
         assign den_src  = dden_ff[j-1];
         assign side_src = dside_ff[j-1];
      end
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            t[i] = {rem_src[i], nq_src[i][NUM_W-1]};
            if (t[i] >= {1'b0, den_src}) begin
               rem_in[i] = DEN_W'(t[i] - {1'b0, den_src});
               nq_in[i]  = {nq_src[i][NUM_W-2:0], 1'b1};
            end else begin
               rem_in[i] = t[i][DEN_W-1:0];
               nq_in[i]  = {nq_src[i][NUM_W-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            drem_ff[j]  <= rem_in;
            nq_ff[j]    <= nq_in;
            dden_ff[j]  <= den_src;
            dside_ff[j] <= side_src;
         end
      end
   end

   // final stage 1: drop the scaling of the root
   logic [2:0][NUM_W-1:0] qs_in, qs_ff;
   side_type              sidef_ff;
   logic [SW-1:0]         shamt;
   always_comb begin
      shamt = {dside_ff[NUM_W-1].k, 1'b0};
      for (int i = 0; i < 3; i++) begin
         qs_in[i] = nq_ff[NUM_W-1][i] >> shamt;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         qs_ff    <= qs_in;
         sidef_ff <= dside_ff[NUM_W-1];
      end
   end

   // final stage 2: clip, apply sign, flag
   logic [FORCE_W-1:0] fv  [3];
   logic [FORCE_W-1:0] fo  [3];
   logic [NUM_W-1:0]   lim [3];
   logic [2:0]         clip;
   rsp_word_type       word_in, word_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lim[i]  = sidef_ff.neg[i] ? (NUM_W'(1) << (FORCE_W - 1))
                                   : ((NUM_W'(1) << (FORCE_W - 1)) - 1'b1);
         clip[i] = qs_ff[i] > lim[i];
         fv[i]   = clip[i] ? lim[i][FORCE_W-1:0] : qs_ff[i][FORCE_W-1:0];
         fo[i]   = sidef_ff.neg[i] ? (~fv[i] + 1'b1) : fv[i];
      end
      if (sidef_ff.coin) begin
         word_in = '0;
         word_in.coincident = 1'b1;
      end else begin
         word_in.force_x    = fo[0];
         word_in.force_y    = fo[1];
         word_in.force_z    = fo[2];
         word_in.coincident = 1'b0;
         word_in.saturated  = |clip;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end
   assign out_word = word_ff;

endmodule

/* rtl/core/coulomb_pair_force_top.sv */
// Top level of the Coulomb pair force block: register port, datapath and output queue
//
//   channel  direction  handshake          word
//   req_ch   in         valid / ready      two positions, two charges
//   rsp_ch   out        valid / ready      force vector, coincident, saturated
//   csr      in         psel / penable     coulomb_scale at every address
//
// One pair is taken every cycle while the output queue is not full; a result is
// offered on rsp_ch once its pair has passed the input register, the 136 pipeline
// stages after it (32 of them root stages, 94 division stages) and the output queue.
// Reset is synchronous, clears the valid bits and the queue and restores the scale.
// A two-word output queue takes the last word in flight; the datapath
// halts only while the queue is full, so ready never depends on rsp_ch.ready.
module coulomb_pair_force_top #(
   parameter int COORD_WIDTH = cpf_pkg::COORD_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   cpf_req_if.sink                            req_ch,
   cpf_rsp_if.source                          rsp_ch,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [cpf_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [cpf_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [cpf_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import cpf_pkg::*;

   // register port: a single register, so every address selects it
   logic [SCALE_W-1:0] scale_ff;
   logic               csr_wr;
   logic               addr_unused;
   assign pready      = 1'b1;
   assign csr_wr      = psel && penable && pwrite && pready;
   assign addr_unused = ^paddr;
   assign prdata      = CSR_DATA_W'(scale_ff) | CSR_DATA_W'(addr_unused & 1'b0);
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr) begin
         scale_ff <= pwdata[SCALE_W-1:0];
      end
   end

   // output queue state
   logic [1:0]   cnt_ff, cnt_in;
   rsp_word_type head_ff, head_in, tail_ff, tail_in;
   logic         en, push, pop;
   logic         pipe_valid;
   rsp_word_type pipe_word;

   assign en           = (cnt_ff != 2'd2);
   assign req_ch.ready = en;

   // datapath
   logic signed [COORD_WIDTH-1:0] a_pos [3];
   logic signed [COORD_WIDTH-1:0] b_pos [3];
   always_comb begin
      a_pos[0] = req_ch.a_x;
      a_pos[1] = req_ch.a_y;
      a_pos[2] = req_ch.a_z;
      b_pos[0] = req_ch.b_x;
      b_pos[1] = req_ch.b_y;
      b_pos[2] = req_ch.b_z;
   end

   cpf_pipe #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .a_pos     (a_pos),
      .b_pos     (b_pos),
      .charge_a  (req_ch.charge_a),
      .charge_b  (req_ch.charge_b),
      .scale     (scale_ff),
      .out_valid (pipe_valid),
      .out_word  (pipe_word)
   );

   // queue: push finished words, pop on the result handshake
   assign push = en && pipe_valid;
   assign pop  = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
      head_in = head_ff;
      tail_in = tail_ff;
      if (push && ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop))) begin
         head_in = pipe_word;
      end else if (pop && (cnt_ff == 2'd2)) begin
         head_in = tail_ff;
      end
      if (push && (cnt_ff == 2'd1) && !pop) begin
         tail_in = pipe_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   // drive the result channel from the queue head
   assign rsp_ch.valid      = (cnt_ff != 2'd0);
   assign rsp_ch.force_x    = head_ff.force_x;
   assign rsp_ch.force_y    = head_ff.force_y;
   assign rsp_ch.force_z    = head_ff.force_z;
   assign rsp_ch.coincident = head_ff.coincident;
   assign rsp_ch.saturated  = head_ff.saturated;

endmodule

/* rtl/core/cpf_checker.sv */
// Port checker for the Coulomb pair force block, bound to the top level
`include "coulomb_pair_force_top_macros.svh"

module cpf_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [cpf_pkg::FORCE_W-1:0] force_x,
   input logic signed [cpf_pkg::FORCE_W-1:0] force_y,
   input logic signed [cpf_pkg::FORCE_W-1:0] force_z,
   input logic                               coincident,
   input logic                               saturated,
   input logic                               pready
);
   import cpf_pkg::*;

   localparam logic [FORCE_W-1:0] F_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
   localparam logic [FORCE_W-1:0] F_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

   // coincident pairs carry no force and no clip flag
   `CPF_ASSERT_SAME(a_coincident_zero, rsp_valid && coincident,
      (force_x == '0) && (force_y == '0) && (force_z == '0) && !saturated,
      "coincident word carries force or clip flag")

   // a clipped word shows a limit value on some axis
   `CPF_ASSERT_SAME(a_sat_limit, rsp_valid && saturated,
      (force_x == F_MAX) || (force_x == F_MIN) || (force_y == F_MAX) ||
      (force_y == F_MIN) || (force_z == F_MAX) || (force_z == F_MIN),
      "saturated word without a limit value")

   // a waiting word stays offered
   `CPF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid,
      "result word withdrawn under stall")

   // register port never waits
   `CPF_ASSERT_SAME(a_pready_high, 1'b1, pready, "pready low")

endmodule

bind coulomb_pair_force_top cpf_checker u_cpf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .force_x    (rsp_ch.force_x),
   .force_y    (rsp_ch.force_y),
   .force_z    (rsp_ch.force_z),
   .coincident (rsp_ch.coincident),
   .saturated  (rsp_ch.saturated),
   .pready     (pready)
);
